// ===== src/dmf_pkg.sv =====
// ----------------------------------------------------------------------------
// dmf_pkg: shared types and constants for the decimating matched filter
// Holds widths, opcodes, the queue entry type and the config register indexes.
// ----------------------------------------------------------------------------
package dmf_pkg;

  localparam int MaxTaps  = 64;
  localparam int IdxW     = $clog2(MaxTaps);
  localparam int CntW     = IdxW + 1;
  localparam int SampW    = 16;
  localparam int AccW     = 40;
  localparam int OutW     = 26;
  localparam int SqW      = 50;   // r*r + i*i, r and i are at most 25 bits signed
  localparam int RootW    = SqW / 2;
  localparam int QDepth   = 2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TAP    = 1'b1;

  localparam logic [0:0] REG_TAP_COUNT  = 1'd0;
  localparam logic [0:0] REG_DECIMATION = 1'd1;

  // one classified beat handed from front to back
  typedef struct packed {
    logic               is_tap;
    logic [IdxW-1:0]    addr;      // delay-line or tap-store address
    logic [SampW-1:0]   re;
    logic [SampW-1:0]   im;
    logic               fire;      // sample completes a decimation cycle
  } cmd_t;

  // clamped configuration seen by both halves
  typedef struct packed {
    logic [CntW-1:0] taps;
    logic [CntW-1:0] dec;
  } cfg_t;

endpackage

// ===== src/dmf_ram.sv =====
// ----------------------------------------------------------------------------
// dmf_ram: generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module dmf_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/dmf_front.sv =====
// ----------------------------------------------------------------------------
// dmf_front: accepts beats, tracks the decimation phase and classifies beats
// Sample beats get their delay-line address; the last of a cycle is marked.
// ----------------------------------------------------------------------------
module dmf_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dmf_pkg::cfg_t            cfg,
  input  logic                     clr,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_opcode,
  input  logic signed [15:0]       in_sample_i,
  input  logic signed [15:0]       in_sample_q,
  input  logic [5:0]               in_tap_index,
  input  logic signed [15:0]       in_tap_re,
  input  logic signed [15:0]       in_tap_im,
  output logic                     q_push,
  output dmf_pkg::cmd_t            q_data,
  input  logic                     q_full
);
  import dmf_pkg::*;

  logic [CntW-1:0] phase_r, phase_nxt, ph_eff, ph_inc;
  logic [CntW-1:0] pos;

  assign in_ready = !q_full && !clr;
  assign q_push   = in_valid && in_ready;

  // phase at or beyond decimation is taken as zero
  always_comb begin
    ph_eff = (phase_r >= cfg.dec) ? '0 : phase_r;
    ph_inc = ph_eff + 1'b1;
    pos    = cfg.taps - cfg.dec + ph_eff;
    q_data.is_tap = (in_opcode == OP_TAP);
    q_data.addr   = q_data.is_tap ? in_tap_index : pos[IdxW-1:0];
    q_data.re     = q_data.is_tap ? in_tap_re : in_sample_i;
    q_data.im     = q_data.is_tap ? in_tap_im : in_sample_q;
    q_data.fire   = !q_data.is_tap && (ph_inc >= cfg.dec);
    phase_nxt     = phase_r;
    if (clr) begin
      phase_nxt = '0;
    end else if (q_push && !q_data.is_tap) begin
      phase_nxt = q_data.fire ? '0 : ph_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== src/dmf_queue.sv =====
// ----------------------------------------------------------------------------
// dmf_queue: short FIFO between the front and back halves
// ----------------------------------------------------------------------------
module dmf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dmf_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output dmf_pkg::cmd_t rdata,
  output logic          empty
);
  import dmf_pkg::*;

  localparam int PtrW = $clog2(QDepth);

  cmd_t            ent_r [QDepth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [PtrW:0]   cnt_r;

  assign full  = (cnt_r == QDepth[PtrW:0]);
  assign empty = (cnt_r == '0);
  assign rdata = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{PtrW{1'b0}}, push} - {{PtrW{1'b0}}, pop};
    end
  end

endmodule

// ===== src/dmf_isqrt.sv =====
// ----------------------------------------------------------------------------
// dmf_isqrt: floor integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module dmf_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dmf_pkg::SqW-1:0]      rad,
  output logic                         done,
  output logic [dmf_pkg::RootW-1:0]    root
);
  import dmf_pkg::*;

  localparam int StW = $clog2(RootW + 1);

  logic [SqW-1:0]   v_r;
  logic [RootW+1:0] rem_r;
  logic [RootW-1:0] q_r;
  logic [StW-1:0]   n_r;
  logic             busy_r;
  logic [RootW+1:0] trial, rem_sh;

  // restoring method: bring down two bits, try 4q+1
  always_comb begin
    rem_sh = {rem_r[RootW-1:0], v_r[SqW-1 -: 2]};
    trial  = {q_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        v_r    <= rad;
        rem_r  <= '0;
        q_r    <= '0;
        n_r    <= StW'(RootW);
      end else if (busy_r) begin
        v_r <= v_r << 2;
        if (rem_sh >= trial) begin
          rem_r <= rem_sh - trial;
          q_r   <= {q_r[RootW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          q_r   <= {q_r[RootW-2:0], 1'b0};
        end
        n_r <= n_r - 1'b1;
        if (n_r == StW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign root = q_r;

endmodule

// ===== src/dmf_back.sv =====
// ----------------------------------------------------------------------------
// dmf_back: executes queued beats: memory writes, correlation, shift, roots
// One shared complex MAC walks the delay line; two root units finish it.
// ----------------------------------------------------------------------------
module dmf_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dmf_pkg::cfg_t              cfg,
  input  logic                       clr,
  output logic                       busy,
  input  logic                       q_empty,
  input  dmf_pkg::cmd_t              q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [25:0]         out_sideband_diff
);
  import dmf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_MAC_RD, S_MAC, S_MUL, S_SQ, S_ROOT, S_OUT, S_SH_RD, S_SH_WR
  } st_t;

  st_t               st_r;
  logic [CntW-1:0]   n_r;
  logic [CntW-1:0]   k_r;
  logic              mv_r;              // MAC read data valid
  logic signed [AccW-1:0] rr_r, ii_r, ir_r, ri_r;
  logic signed [31:0] prr_r, pii_r, pir_r, pri_r;
  logic              pv_r;
  logic signed [AccW-1:0] rn_r, rp_r, in_r, ip_r;
  logic [SqW-1:0]    sqn_r, sqp_r;
  logic [1:0]        sqs_r;
  logic signed [25:0] out_r;
  logic              ov_r;
  logic [RootW-1:0]  mag_n, mag_p;
  logic              dn_n, dn_p, rt_start;

  // delay line and tap store
  logic              lwe, twe;
  logic [IdxW-1:0]   lwa, lra, tra;
  logic [31:0]       lwd, lrd, trd;

  dmf_ram #(.Width(32), .Depth(MaxTaps)) u_line (
    .clk(clk), .we(lwe), .waddr(lwa), .wdata(lwd), .raddr(lra), .rdata(lrd));
  dmf_ram #(.Width(32), .Depth(MaxTaps)) u_taps (
    .clk(clk), .we(twe), .waddr(q_data.addr), .wdata({q_data.re, q_data.im}),
    .raddr(tra), .rdata(trd));

  dmf_isqrt u_rt_n (.clk(clk), .rst_n(rst_n), .start(rt_start), .rad(sqn_r),
                    .done(dn_n), .root(mag_n));
  dmf_isqrt u_rt_p (.clk(clk), .rst_n(rst_n), .start(rt_start), .rad(sqp_r),
                    .done(dn_p), .root(mag_p));

  logic [CntW-1:0] sh_src;
  logic signed [AccW-1:0] a_rn, a_rp, a_in, a_ip;
  logic signed [SampW-1:0] sr, si, tr, ti;
  logic signed [24:0] sq_a, sq_b;

  assign sh_src = n_r + cfg.dec;
  assign sr = lrd[31:16];
  assign si = lrd[15:0];
  assign tr = trd[31:16];
  assign ti = trd[15:0];
  assign a_rn = rr_r + ii_r;
  assign a_rp = rr_r - ii_r;
  assign a_in = ir_r - ri_r;
  assign a_ip = ir_r + ri_r;

  // squaring operands, two per cycle: n first, then p
  assign sq_a = (sqs_r == 2'd0) ? rn_r[24:0] : rp_r[24:0];
  assign sq_b = (sqs_r == 2'd0) ? in_r[24:0] : ip_r[24:0];

  // memory port steering
  always_comb begin
    lwe = 1'b0; lwa = q_data.addr; lwd = {q_data.re, q_data.im};
    twe = 1'b0;
    lra = n_r[IdxW-1:0];
    tra = k_r[IdxW-1:0];
    q_pop = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (!q_empty && !clr) begin
          q_pop = 1'b1;
          lwe   = !q_data.is_tap;
          twe   = q_data.is_tap;
        end
      end
      S_CLEAR: begin
        lwe = 1'b1; lwa = n_r[IdxW-1:0]; lwd = '0;
      end
      S_SH_RD: lra = sh_src[IdxW-1:0];
      S_SH_WR: begin
        lwe = 1'b1; lwa = n_r[IdxW-1:0]; lwd = lrd;
      end
      default: ;
    endcase
  end

  assign busy      = (st_r != S_IDLE) || !q_empty;
  assign out_valid = ov_r;
  assign out_sideband_diff = out_r;
  assign rt_start  = (st_r == S_SQ) && (sqs_r == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_CLEAR;
      n_r    <= '0;
      ov_r   <= 1'b0;
      mv_r   <= 1'b0;
      pv_r   <= 1'b0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (clr) begin
            st_r <= S_CLEAR;
            n_r  <= '0;
          end else if (!q_empty && !q_data.is_tap && q_data.fire) begin
            st_r <= S_MAC_RD;
            n_r  <= '0;
            k_r  <= cfg.taps - 1'b1;
            rr_r <= '0; ii_r <= '0; ir_r <= '0; ri_r <= '0;
            mv_r <= 1'b0; pv_r <= 1'b0;
          end
        end
        // zero the whole delay line, one entry per cycle
        S_CLEAR: begin
          n_r <= n_r + 1'b1;
          if (n_r == CntW'(MaxTaps - 1)) st_r <= S_IDLE;
        end
        // address issue, product stage, accumulate stage
        S_MAC_RD, S_MAC: begin
          st_r <= S_MAC;
          mv_r <= (n_r < cfg.taps);
          if (n_r < cfg.taps) begin
            n_r <= n_r + 1'b1;
            k_r <= k_r - 1'b1;
          end
          pv_r  <= mv_r;
          prr_r <= sr * tr;
          pii_r <= si * ti;
          pir_r <= si * tr;
          pri_r <= sr * ti;
          if (pv_r) begin
            rr_r <= rr_r + AccW'(prr_r);
            ii_r <= ii_r + AccW'(pii_r);
            ir_r <= ir_r + AccW'(pir_r);
            ri_r <= ri_r + AccW'(pri_r);
          end
          if (!mv_r && !pv_r && st_r == S_MAC) st_r <= S_MUL;
        end
        // combine and floor-shift
        S_MUL: begin
          rn_r  <= a_rn >>> 16;
          rp_r  <= a_rp >>> 16;
          in_r  <= a_in >>> 16;
          ip_r  <= a_ip >>> 16;
          sqs_r <= 2'd0;
          st_r  <= S_SQ;
        end
        S_SQ: begin
          if (sqs_r == 2'd0) sqn_r <= SqW'(sq_a * sq_a) + SqW'(sq_b * sq_b);
          if (sqs_r == 2'd1) sqp_r <= SqW'(sq_a * sq_a) + SqW'(sq_b * sq_b);
          sqs_r <= sqs_r + 1'b1;
          if (sqs_r == 2'd2) st_r <= S_ROOT;
        end
        // both roots finish together; they hold until the next start
        S_ROOT: begin
          if (dn_n && dn_p) st_r <= S_OUT;
        end
        // load the result only once the previous beat has left
        S_OUT: begin
          if (!ov_r) begin
            ov_r  <= 1'b1;
            out_r <= 26'($signed({1'b0, mag_p}) - $signed({1'b0, mag_n}));
            n_r   <= '0;
            st_r  <= S_SH_RD;
          end
        end
        // shift the line down by the decimation factor
        S_SH_RD: begin
          if (sh_src < cfg.taps) st_r <= S_SH_WR;
          else st_r <= S_IDLE;
        end
        S_SH_WR: begin
          n_r  <= n_r + 1'b1;
          st_r <= S_SH_RD;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/decimating_matched_filter_sideband_diff_unit.sv =====
// ----------------------------------------------------------------------------
// decimating_matched_filter_sideband_diff_unit: decimating complex matched
// filter emitting |plain product| - |conjugate product|.
//
//   channel | direction | ports
//   in      | in        | in_valid/in_ready, opcode, samples, tap fields
//   out     | out       | out_valid/out_ready, sideband_diff
//   cfg     | in        | cfg_valid/cfg_ready, cfg_index, cfg_data
//
// A tap write or a non-final sample is a single memory write in the back half.
// A decimation cycle's final sample then runs through the shared complex
// MAC, the squares, the bit-serial roots, the output and the line shift.
// After reset and after each config write a pass zeroes the whole line;
// meanwhile at most two beats wait in the queue. A config write waits until
// the back half is idle and the queue is empty. A stalled output holds the
// back half.
// ----------------------------------------------------------------------------
module decimating_matched_filter_sideband_diff_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic signed [15:0] in_sample_i,
  input  logic signed [15:0] in_sample_q,
  input  logic [5:0]         in_tap_index,
  input  logic signed [15:0] in_tap_re,
  input  logic signed [15:0] in_tap_im,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [25:0] out_sideband_diff,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [6:0]         cfg_data
);
  import dmf_pkg::*;

  logic [6:0] taps_r, dec_r;
  cfg_t       cfg;
  logic       clr, busy, q_push, q_pop, q_full, q_empty, f_ready;
  cmd_t       q_wd, q_rd;
  logic [6:0] t_eff, d_eff;

  // clamp config to its legal range
  always_comb begin
    t_eff = (taps_r == '0) ? 7'd1 : (taps_r > 7'(MaxTaps) ? 7'(MaxTaps) : taps_r);
    d_eff = (dec_r == '0) ? 7'd1 : (dec_r > t_eff ? t_eff : dec_r);
    cfg.taps = CntW'(t_eff);
    cfg.dec  = CntW'(d_eff);
  end

  // config is taken only with nothing in flight
  assign cfg_ready = !busy;
  assign clr       = cfg_valid && cfg_ready;
  assign in_ready  = f_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r <= 7'd64;
      dec_r  <= 7'd1;
    end else if (clr) begin
      if (cfg_index == REG_TAP_COUNT) taps_r <= cfg_data;
      if (cfg_index == REG_DECIMATION) dec_r <= cfg_data;
    end
  end

  dmf_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .clr(clr),
    .in_valid(in_valid), .in_ready(f_ready), .in_opcode(in_opcode),
    .in_sample_i(in_sample_i), .in_sample_q(in_sample_q),
    .in_tap_index(in_tap_index), .in_tap_re(in_tap_re), .in_tap_im(in_tap_im),
    .q_push(q_push), .q_data(q_wd), .q_full(q_full));

  dmf_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wdata(q_wd), .full(q_full),
    .pop(q_pop), .rdata(q_rd), .empty(q_empty));

  dmf_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .clr(clr), .busy(busy),
    .q_empty(q_empty), .q_data(q_rd), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_sideband_diff(out_sideband_diff));

endmodule

// ===== src/dmf_checker.sv =====
// ----------------------------------------------------------------------------
// dmf_checker: port-level checks on the matched filter top level
// ----------------------------------------------------------------------------
module dmf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [25:0] out_sideband_diff,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // a waiting result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sideband_diff))
    else $error("result changed while stalled");

  // no beat is taken during a config write
  a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> !in_ready)
    else $error("input taken during config write");

  // nothing is presented right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

  // at most one result per decimation cycle: a bubble follows each beat
  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("results back to back");

endmodule

bind decimating_matched_filter_sideband_diff_unit dmf_checker u_dmf_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_sideband_diff(out_sideband_diff), .cfg_valid(cfg_valid),
  .cfg_ready(cfg_ready));
